[design/saa_pkg.sv]
package saa_pkg;

	typedef logic [2:0] state_t;

	localparam state_t ST_CLEAR  = 3'd0;
	localparam state_t ST_IDLE   = 3'd1;
	localparam state_t ST_PRE    = 3'd2;
	localparam state_t ST_SUF    = 3'd3;
	localparam state_t ST_DECIDE = 3'd4;
	localparam state_t ST_WRITE  = 3'd5;
	localparam state_t ST_RESP   = 3'd6;

endpackage

[design/skyline_atlas_allocator_unit.sv]
// Skyline rectangle allocator for a set of square texture pages.
// The request channel (req_valid, req_ready) takes one word with mode, rect_width and
// rect_height. Mode 1 clears every column height of every page. Mode 0 places a rectangle.
// The response channel (rsp_valid, rsp_ready) returns exactly one word per request:
// page, pos_x, pos_y and full_res.
// A request is taken only while the block is idle. An allocation scans each page it tries
// in two passes over the column height memory, one column per cycle each: a left-to-right
// pass stores the block-wise running maximum in a scratch memory, and a right-to-left pass
// forms each window maximum and keeps the best start column. A placement then raises the
// rect_width columns it covers to the top of the rectangle. The height memory has a single read port.
// A clear request sweeps the height memory, one entry per cycle, before its response.
// After reset the same sweep runs with req_ready low and gives no response.
// The response sits in an output register; a stalled receiver holds it there, a new request
// may then be taken, and its result waits until the register is free.
module skyline_atlas_allocator_unit #(
	parameter int NUM_PAGES   = 2,
	parameter int PAGE_WIDTH  = 256,
	parameter int PAGE_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic       mode,
	input  logic [7:0] rect_width,
	input  logic [7:0] rect_height,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic       page,
	output logic [7:0] pos_x,
	output logic [7:0] pos_y,
	output logic       full_res
);

	import saa_pkg::*;

	localparam int TOTAL = NUM_PAGES * PAGE_WIDTH;
	localparam int AW    = $clog2(TOTAL);
	localparam int CIW   = $clog2(PAGE_WIDTH);
	localparam int HW    = $clog2(PAGE_HEIGHT + 1);
	localparam int PGW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int WCW   = $clog2(PAGE_WIDTH + 1);
	localparam int KW    = ((WCW > 8) ? WCW : 8) + 1;
	localparam int SW    = ((HW > 8) ? HW : 8) + 1;

	logic [HW-1:0] heights [TOTAL];
	logic [HW-1:0] scratch [PAGE_WIDTH];

	state_t         state_q;
	logic           clr_rsp_q;
	logic [AW-1:0]  clr_addr_q;
	logic [7:0]     w_q;
	logic [7:0]     h_q;
	logic [PGW-1:0] page_q;
	logic [AW-1:0]  base_q;
	logic [CIW-1:0] iss_q;
	logic           iss_on_q;
	logic           v_s1;
	logic [CIW-1:0] col_s1;
	logic           last_s1;
	logic [HW-1:0]  rd_h_q;
	logic [HW-1:0]  rd_r_q;
	logic [7:0]     pos_q;
	logic [HW-1:0]  run_q;
	logic [HW-1:0]  best_q;
	logic [CIW-1:0] bx_q;
	logic           found_q;
	logic [CIW-1:0] wcol_q;
	logic [7:0]     wcnt_q;
	logic           res_full_q;
	logic           res_zero_q;
	logic           rsp_valid_q;
	logic           out_page_q;
	logic [7:0]     out_x_q;
	logic [7:0]     out_y_q;
	logic           out_full_q;

	logic           accept;
	logic           refuse;
	logic [HW-1:0]  max_h;
	logic [HW-1:0]  pre_run;
	logic [HW-1:0]  suf_run;
	logic [HW-1:0]  cand_m;
	logic           cand_in;
	logic           cand_take;
	logic [SW-1:0]  top_sum;
	logic           fits;
	logic [KW-1:0]  sra_sum;
	logic [CIW-1:0] sra;
	logic [AW-1:0]  hra;
	logic           hwe;
	logic [AW-1:0]  hwa;
	logic [HW-1:0]  hwd;
	logic           swe;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign refuse    = (rect_width == 8'd0) || (rect_height == 8'd0) ||
		(KW'(rect_width) >= KW'(PAGE_WIDTH));

	assign max_h   = (rd_h_q > run_q) ? rd_h_q : run_q;
	assign pre_run = (pos_q == 8'd0) ? rd_h_q : max_h;
	assign suf_run = ((pos_q == w_q - 8'd1) || (col_s1 == CIW'(PAGE_WIDTH - 1))) ?
		rd_h_q : max_h;
	assign cand_m  = (suf_run > rd_r_q) ? suf_run : rd_r_q;
	assign cand_in = (KW'(col_s1) + KW'(w_q)) < KW'(PAGE_WIDTH);
	assign cand_take = cand_in && (cand_m < HW'(PAGE_HEIGHT)) && (cand_m <= best_q);

	assign top_sum = SW'(best_q) + SW'(h_q);
	assign fits    = top_sum <= SW'(PAGE_HEIGHT);

	assign sra_sum = KW'(iss_q) + KW'(w_q) - KW'(1);
	assign sra     = (sra_sum < KW'(PAGE_WIDTH)) ? sra_sum[CIW-1:0] : '0;
	assign hra     = base_q + AW'(iss_q);

	assign hwe = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign hwa = (state_q == ST_CLEAR) ? clr_addr_q : base_q + AW'(wcol_q);
	assign hwd = (state_q == ST_CLEAR) ? '0 : top_sum[HW-1:0];
	assign swe = v_s1 && (state_q == ST_PRE);

	always_ff @(posedge clk) begin
		if (hwe) begin
			heights[hwa] <= hwd;
		end
		rd_h_q <= heights[hra];
	end

	always_ff @(posedge clk) begin
		if (swe) begin
			scratch[col_s1] <= pre_run;
		end
		rd_r_q <= scratch[sra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_rsp_q   <= 1'b0;
			clr_addr_q  <= '0;
			w_q         <= '0;
			h_q         <= '0;
			page_q      <= '0;
			base_q      <= '0;
			iss_q       <= '0;
			iss_on_q    <= 1'b0;
			v_s1        <= 1'b0;
			col_s1      <= '0;
			last_s1     <= 1'b0;
			pos_q       <= '0;
			run_q       <= '0;
			best_q      <= '0;
			bx_q        <= '0;
			found_q     <= 1'b0;
			wcol_q      <= '0;
			wcnt_q      <= '0;
			res_full_q  <= 1'b0;
			res_zero_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			out_page_q  <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_full_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end

			v_s1    <= iss_on_q && ((state_q == ST_PRE) || (state_q == ST_SUF));
			col_s1  <= iss_q;
			last_s1 <= (state_q == ST_PRE) ? (iss_q == CIW'(PAGE_WIDTH - 1)) :
				(iss_q == '0);

			case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == AW'(TOTAL - 1)) begin
						clr_addr_q <= '0;
						res_full_q <= 1'b0;
						res_zero_q <= 1'b1;
						state_q    <= clr_rsp_q ? ST_RESP : ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						w_q <= rect_width;
						h_q <= rect_height;
						if (mode) begin
							clr_rsp_q  <= 1'b1;
							clr_addr_q <= '0;
							state_q    <= ST_CLEAR;
						end else if (refuse) begin
							res_full_q <= 1'b1;
							res_zero_q <= 1'b1;
							state_q    <= ST_RESP;
						end else begin
							page_q   <= '0;
							base_q   <= '0;
							iss_q    <= '0;
							iss_on_q <= 1'b1;
							pos_q    <= '0;
							best_q   <= HW'(PAGE_HEIGHT);
							found_q  <= 1'b0;
							state_q  <= ST_PRE;
						end
					end
				end
				ST_PRE: begin
					if (iss_on_q) begin
						iss_q <= iss_q + CIW'(1);
						if (iss_q == CIW'(PAGE_WIDTH - 1)) begin
							iss_on_q <= 1'b0;
						end
					end
					if (v_s1) begin
						run_q <= pre_run;
						if (last_s1) begin
							iss_q    <= CIW'(PAGE_WIDTH - 1);
							iss_on_q <= 1'b1;
							state_q  <= ST_SUF;
						end else begin
							pos_q <= (pos_q == w_q - 8'd1) ? 8'd0 : pos_q + 8'd1;
						end
					end
				end
				ST_SUF: begin
					if (iss_on_q) begin
						iss_q <= iss_q - CIW'(1);
						if (iss_q == '0) begin
							iss_on_q <= 1'b0;
						end
					end
					if (v_s1) begin
						run_q <= suf_run;
						pos_q <= (pos_q == 8'd0) ? w_q - 8'd1 : pos_q - 8'd1;
						if (cand_take) begin
							best_q  <= cand_m;
							bx_q    <= col_s1;
							found_q <= 1'b1;
						end
						if (last_s1) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (found_q && fits) begin
						wcol_q  <= bx_q;
						wcnt_q  <= w_q;
						state_q <= ST_WRITE;
					end else if (page_q == PGW'(NUM_PAGES - 1)) begin
						res_full_q <= 1'b1;
						res_zero_q <= 1'b1;
						state_q    <= ST_RESP;
					end else begin
						page_q   <= page_q + PGW'(1);
						base_q   <= base_q + AW'(PAGE_WIDTH);
						iss_q    <= '0;
						iss_on_q <= 1'b1;
						pos_q    <= '0;
						best_q   <= HW'(PAGE_HEIGHT);
						found_q  <= 1'b0;
						state_q  <= ST_PRE;
					end
				end
				ST_WRITE: begin
					wcol_q <= wcol_q + CIW'(1);
					wcnt_q <= wcnt_q - 8'd1;
					if (wcnt_q == 8'd1) begin
						res_full_q <= 1'b0;
						res_zero_q <= 1'b0;
						state_q    <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						out_page_q  <= res_zero_q ? 1'b0 : page_q[0];
						out_x_q     <= res_zero_q ? 8'd0 : 8'(bx_q);
						out_y_q     <= res_zero_q ? 8'd0 : 8'(best_q);
						out_full_q  <= res_full_q;
						clr_rsp_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign page      = out_page_q;
	assign pos_x     = out_x_q;
	assign pos_y     = out_y_q;
	assign full_res  = out_full_q;

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && out_full_q) |-> (!out_page_q && (out_x_q == 8'd0) && (out_y_q == 8'd0)))
		else $error("full word carries a nonzero position");

	a_write_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (found_q && fits))
		else $error("column raise beyond the page height");

	a_found_low: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_q < HW'(PAGE_HEIGHT)))
		else $error("chosen window maximum at or above the page height");

	a_scan_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ((state_q == ST_PRE) || (state_q == ST_SUF)))
		else $error("column read returned outside a scan pass");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("block still ready after taking a word");

endmodule
